// File: hw/rtl/fpup_pkg.sv
// Shared constants, status codes and types of the framed position update parser.
// No dependencies.
`default_nettype none

package fpup_pkg;

  localparam int NUM_ENTRIES = 5;
  localparam int MAX_PAIRS   = 16;

  localparam int ID_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SLOT_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int IDX_W  = 9;
  localparam int MASK_W = 5;
  localparam int STAT_W = 3;

  localparam logic [7:0]       HEADER_BYTE = 8'hAA;
  localparam int               MIN_LEN     = 4;
  localparam int               FIRST_PAIR  = 3;
  localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};

  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_HDR   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_SHORT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CSUM  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_COUNT = 3'd4;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] id;
    logic [7:0]      pos;
  } pair_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    pair_t             data;
  } pair_wr_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  pairs;
  } finish_t;

endpackage

`default_nettype wire

// File: hw/rtl/fpup_frame.sv
// Byte tracker: header, pair count, running XOR, checksum and frame status.
// Depends on fpup_pkg.
`default_nettype none

module fpup_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic               clear_i,
  input  wire logic [7:0]         data_byte_i,
  output fpup_pkg::pair_wr_t      pair_wr_o,
  output fpup_pkg::finish_t       finish_o
);
  import fpup_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       npairs_q, npairs_d;
  logic [7:0]       idhold_q, idhold_d;
  logic             hdr_q, hdr_d;
  logic             good_q, good_d;
  logic             seen_q, seen_d;

  logic [IDX_W:0]   idx_ext;
  logic [IDX_W:0]   ck;
  logic [IDX_W:0]   off;
  logic [IDX_W-1:0] slot;

  assign idx_ext = {1'b0, idx_q};
  assign ck      = (IDX_W+1)'(FIRST_PAIR) + {1'b0, npairs_q, 1'b0};
  assign off     = idx_ext - (IDX_W+1)'(FIRST_PAIR);
  assign slot    = off[IDX_W:1];

  always_comb begin
    idx_d    = idx_q;
    xor_d    = xor_q;
    npairs_d = npairs_q;
    idhold_d = idhold_q;
    hdr_d    = hdr_q;
    good_d   = good_q;
    seen_d   = seen_q;
    pair_wr_o.en       = 1'b0;
    pair_wr_o.slot     = slot[SLOT_W-1:0];
    pair_wr_o.data.hit = (idhold_q < 8'(NUM_ENTRIES));
    pair_wr_o.data.id  = idhold_q[ID_W-1:0];
    pair_wr_o.data.pos = data_byte_i;
    if (take_i) begin
      if (idx_q == '0) begin
        hdr_d = (data_byte_i == HEADER_BYTE);
      end
      if (idx_q == IDX_W'(2)) begin
        npairs_d = data_byte_i;
      end
      if (idx_ext < (IDX_W+1)'(FIRST_PAIR)) begin
        xor_d = xor_q ^ data_byte_i;
      end else if (idx_ext < ck) begin
        xor_d = xor_q ^ data_byte_i;
        if (slot < IDX_W'(MAX_PAIRS)) begin
          if (!off[0]) begin
            idhold_d = data_byte_i;
          end else begin
            pair_wr_o.en = 1'b1;
          end
        end
      end else if (idx_ext == ck && !seen_q) begin
        seen_d = 1'b1;
        good_d = (xor_q == data_byte_i);
      end
      if (idx_q != IDX_MAX) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
    if (clear_i) begin
      idx_d    = '0;
      xor_d    = '0;
      npairs_d = '0;
      hdr_d    = 1'b0;
      good_d   = 1'b0;
      seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      xor_q    <= '0;
      npairs_q <= '0;
      hdr_q    <= 1'b0;
      good_q   <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      xor_q    <= xor_d;
      npairs_q <= npairs_d;
      hdr_q    <= hdr_d;
      good_q   <= good_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idhold_q <= idhold_d;
  end

  always_comb begin
    if (idx_q < IDX_W'(MIN_LEN) || !hdr_q) begin
      finish_o.status = STAT_HDR;
    end else if (npairs_q > 8'(MAX_PAIRS)) begin
      finish_o.status = STAT_COUNT;
    end else if (idx_ext <= ck) begin
      finish_o.status = STAT_SHORT;
    end else if (!seen_q || !good_q) begin
      finish_o.status = STAT_CSUM;
    end else begin
      finish_o.status = STAT_OK;
    end
    finish_o.pairs = npairs_q[CNT_W-1:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/fpup_apply.sv
// Pair memory and position memory with the sequencer that applies buffered pairs.
// Depends on fpup_pkg.
`default_nettype none

module fpup_apply (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fpup_pkg::pair_wr_t           pair_wr_i,
  input  wire logic                         start_i,
  input  wire logic [fpup_pkg::CNT_W-1:0]   pairs_i,
  output logic                              done_o,
  output logic [fpup_pkg::MASK_W-1:0]       mask_o
);
  import fpup_pkg::*;

  localparam logic [1:0] A_IDLE  = 2'd0;
  localparam logic [1:0] A_RDPR  = 2'd1;
  localparam logic [1:0] A_RDPOS = 2'd2;
  localparam logic [1:0] A_WRITE = 2'd3;

  pair_t            pair_mem [MAX_PAIRS];
  logic [7:0]       pos_mem  [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_q;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              done_q, done_d;
  pair_t             pair_rd_q;
  logic [7:0]        pos_rd_q;
  logic              pos_vld_q;
  logic [7:0]        cur_pos;
  logic              pos_we;

  assign cur_pos = pos_vld_q ? pos_rd_q : 8'd0;
  assign pos_we  = (state_q == A_WRITE) && pair_rd_q.hit && (cur_pos != pair_rd_q.pos);
  assign done_o  = done_q;
  assign mask_o  = mask_q;

  always_ff @(posedge clk_i) begin
    if (pair_wr_i.en) begin
      pair_mem[pair_wr_i.slot] <= pair_wr_i.data;
    end
    if (state_q == A_RDPR) begin
      pair_rd_q <= pair_mem[k_q[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pair_rd_q.id] <= pair_rd_q.pos;
    end
    if (state_q == A_RDPOS && pair_rd_q.hit) begin
      pos_rd_q <= pos_mem[pair_rd_q.id];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      pos_vld_q <= 1'b0;
    end else begin
      if (pos_we) begin
        vld_q[pair_rd_q.id] <= 1'b1;
      end
      if (state_q == A_RDPOS && pair_rd_q.hit) begin
        pos_vld_q <= vld_q[pair_rd_q.id];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    n_d     = n_q;
    mask_d  = mask_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          k_d    = '0;
          n_d    = pairs_i;
          mask_d = '0;
          if (pairs_i == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = A_RDPR;
          end
        end
      end
      A_RDPR: begin
        state_d = A_RDPOS;
      end
      A_RDPOS: begin
        state_d = A_WRITE;
      end
      A_WRITE: begin
        if (pos_we && int'(pair_rd_q.id) < MASK_W) begin
          mask_d = mask_q | (MASK_W'(1) << pair_rd_q.id);
        end
        k_d = k_q + CNT_W'(1);
        if (k_d == n_q) begin
          done_d  = 1'b1;
          state_d = A_IDLE;
        end else begin
          state_d = A_RDPR;
        end
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      mask_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
      mask_q  <= mask_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/framed_position_update_parser.sv
// Framed position update parser: takes frame bytes one request at a time and
// returns one status/mask result per frame. A byte that is not the last of its
// frame is taken whenever the parser is receiving. After the last byte the
// input is held off while the frame is checked and, on a good frame, while
// each pair is walked through the pair memory and the position memory in
// three steps (pair read, position read, write-back). A finished result waits
// in the output register while the next frame's bytes are taken.
// Depends on fpup_pkg, fpup_frame and fpup_apply.
`default_nettype none

module framed_position_update_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fpup_pkg::STAT_W-1:0]        frame_status_o,
  output logic [fpup_pkg::MASK_W-1:0]        moved_mask_o
);
  import fpup_pkg::*;

  localparam logic [1:0] S_RX    = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STAT_W-1:0] pend_status_q, pend_status_d;
  logic [MASK_W-1:0] pend_mask_q, pend_mask_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [MASK_W-1:0] mask_q, mask_d;

  logic              take;
  logic              clear;
  logic              start;
  logic              apply_done;
  logic [MASK_W-1:0] apply_mask;
  pair_wr_t          pair_wr;
  finish_t           finish;

  assign in_ready_o     = (state_q == S_RX);
  assign take           = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign moved_mask_o   = mask_q;

  fpup_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .clear_i     (clear),
    .data_byte_i (data_byte_i),
    .pair_wr_o   (pair_wr),
    .finish_o    (finish)
  );

  fpup_apply u_apply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pair_wr_i (pair_wr),
    .start_i   (start),
    .pairs_i   (finish.pairs),
    .done_o    (apply_done),
    .mask_o    (apply_mask)
  );

  always_comb begin
    state_d       = state_q;
    pend_status_d = pend_status_q;
    pend_mask_d   = pend_mask_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    mask_d        = mask_q;
    clear         = 1'b0;
    start         = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_RX: begin
        if (take && last_byte_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        pend_status_d = finish.status;
        pend_mask_d   = '0;
        if (finish.status == STAT_OK) begin
          start   = 1'b1;
          state_d = S_APPLY;
        end else begin
          state_d = S_OUT;
        end
      end
      S_APPLY: begin
        if (apply_done) begin
          pend_mask_d = apply_mask;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = pend_status_q;
          mask_d      = pend_mask_q;
          clear       = 1'b1;
          state_d     = S_RX;
        end
      end
      default: begin
        state_d = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_mask_q   <= pend_mask_d;
    status_q      <= status_d;
    mask_q        <= mask_d;
  end

endmodule

`default_nettype wire
